// File: design/bcd_pkg.sv
// Package for the buffer cache directory: command, status and state codes,
// slot record types and small helper functions. No dependencies.
package bcd_pkg;

	localparam int NUM_SLOTS_DEF = 32;
	localparam int IDX_W = 6;
	localparam logic [31:0] LIMIT_RST = 32'd1048576;
	localparam logic [15:0] CNT_MAX = 16'hFFFF;
	localparam int FLAG_VALID = 0;
	localparam int FLAG_WRITABLE = 1;

	typedef enum logic [3:0] {
		CMD_LOOKUP = 4'd0, CMD_ALLOC = 4'd1, CMD_REL_READ = 4'd2,
		CMD_WRITE_REF = 4'd3, CMD_REL_WRITE = 4'd4, CMD_LOCK = 4'd5,
		CMD_UNLOCK = 4'd6, CMD_SET_VALID = 4'd7, CMD_SET_INVALID = 4'd8,
		CMD_SET_WRITABLE = 4'd9, CMD_SET_CLEAN = 4'd10, CMD_RENAME = 4'd11
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HIT = 3'd0, ST_INSERTED = 3'd1, ST_MISS = 3'd2, ST_OK = 3'd3,
		ST_NO_FREE = 3'd4, ST_UNDERFLOW = 3'd5
	} status_t;

	typedef enum logic [0:0] {
		KIND_RESP = 1'b0, KIND_WRITEBACK = 1'b1
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_FIND, S_NOTFOUND, S_RNDROP, S_RNKEY,
		S_EVCHK, S_ROT, S_WB, S_DROPV, S_ALLOC
	} state_t;

	typedef struct packed {
		logic [7:0]  key_type;
		logic [63:0] key_space;
		logic [63:0] key_inode;
		logic [7:0]  key_level;
		logic [63:0] key_offset;
	} key_t;

	typedef struct packed {
		logic [15:0] rc;
		logic [15:0] wc;
		logic [15:0] lc;
		logic [15:0] uc;
		logic [1:0]  flags;
	} cnt_t;

	typedef struct packed {
		key_t             key;
		logic [23:0]      bytes;
		cnt_t             cnt;
		logic [IDX_W-1:0] next;
	} slot_rd_t;

	typedef struct packed {
		logic             entry_we;
		logic             key_we;
		logic             cnt_we;
		logic             free_we;
		logic             next_we;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] next_addr;
		logic [IDX_W-1:0] next_data;
		key_t             key;
		logic [23:0]      bytes;
		cnt_t             cnt;
	} slot_wr_t;

	typedef struct packed {
		logic       kind;
		logic [2:0] status;
		logic [4:0] result_slot;
		logic       valid_flag;
		logic       writable_flag;
		logic       last;
	} rsp_t;

	function automatic logic [15:0] inc_sat(input logic [15:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
	endfunction

	function automatic logic cnt_idle(input cnt_t c);
		return (c.rc == 16'd0) && (c.wc == 16'd0) && (c.lc == 16'd0);
	endfunction

	function automatic rsp_t make_rsp(input kind_t k, input status_t st,
			input logic [4:0] s, input logic [1:0] fl, input logic lst);
		rsp_t r;
		r.kind = k;
		r.status = st;
		r.result_slot = s;
		r.valid_flag = fl[FLAG_VALID];
		r.writable_flag = fl[FLAG_WRITABLE];
		r.last = lst;
		return r;
	endfunction

endpackage

// File: design/bcd_if.sv
// Channel interfaces of the buffer cache directory: request, response and
// configuration write. No dependencies.
interface bcd_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  command;
	logic [7:0]  key_type;
	logic [63:0] key_space;
	logic [63:0] key_inode;
	logic [7:0]  key_level;
	logic [63:0] key_offset;
	logic [23:0] buf_size;
	logic [4:0]  slot;
	modport source(output valid, command, key_type, key_space, key_inode, key_level,
		key_offset, buf_size, slot, input ready);
	modport sink(input valid, command, key_type, key_space, key_inode, key_level,
		key_offset, buf_size, slot, output ready);
endinterface

interface bcd_rsp_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [2:0] status;
	logic [4:0] result_slot;
	logic       valid_flag;
	logic       writable_flag;
	logic       last;
	modport source(output valid, kind, status, result_slot, valid_flag, writable_flag,
		last, input ready);
	modport sink(input valid, kind, status, result_slot, valid_flag, writable_flag,
		last, output ready);
endinterface

interface bcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

// File: design/bcd_slots.sv
// Slot record store: keys, sizes, counts, flags and order links, one read
// address, one write per field group per cycle. Depends on bcd_pkg.
module bcd_slots import bcd_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     rd_addr,
	output slot_rd_t             rd,
	input  slot_wr_t             wr,
	output logic [NUM_SLOTS-1:0] used,
	output logic [NUM_SLOTS-1:0] idle
);
	localparam int SW = $clog2(NUM_SLOTS);

	key_t          key_q   [NUM_SLOTS];
	logic [23:0]   bytes_q [NUM_SLOTS];
	cnt_t          cnt_q   [NUM_SLOTS];
	logic [SW-1:0] next_q  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] used_q;
	logic [NUM_SLOTS-1:0] idle_q;
	logic [SW-1:0] ra, wa, na;

	assign ra = SW'(rd_addr);
	assign wa = SW'(wr.addr);
	assign na = SW'(wr.next_addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (wr.entry_we) used_q[wa] <= 1'b1;
			if (wr.free_we) used_q[wa] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.entry_we || wr.key_we) key_q[wa] <= wr.key;
		if (wr.entry_we) bytes_q[wa] <= wr.bytes;
		if (wr.entry_we || wr.cnt_we) begin
			cnt_q[wa] <= wr.cnt;
			idle_q[wa] <= cnt_idle(wr.cnt);
		end
		if (wr.next_we) next_q[na] <= SW'(wr.next_data);
	end

	always_comb begin
		rd.key = key_q[ra];
		rd.bytes = bytes_q[ra];
		rd.cnt = cnt_q[ra];
		rd.next = IDX_W'(next_q[ra]);
	end

	assign used = used_q;
	assign idle = idle_q;

endmodule

// File: design/bcd_seq.sv
// Command sequencer: order list walk, eviction rotation, allocation, count
// and flag updates, byte total and response register. Depends on bcd_pkg,
// bcd_if.
module bcd_seq import bcd_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	bcd_req_if.sink              req,
	bcd_rsp_if.source            rsp,
	bcd_cfg_if.sink              cfg,
	output logic [IDX_W-1:0]     rd_addr,
	input  slot_rd_t             rd,
	output slot_wr_t             wr,
	input  logic [NUM_SLOTS-1:0] used,
	input  logic [NUM_SLOTS-1:0] idle
);
	localparam int SW = $clog2(NUM_SLOTS);

	state_t state_q, state_d;
	logic [3:0]    cmd_q;
	key_t          key_q;
	logic [23:0]   size_q;
	logic [4:0]    slot_q;
	logic [SW-1:0] cur_q, cur_d, prev_q, prev_d, head_q, head_d, tail_q, tail_d;
	logic          prev_vld_q, prev_vld_d, head_vld_q, head_vld_d;
	logic [31:0]   bytes_q, bytes_d, limit_q;
	rsp_t          out_q, emit_d;
	logic          ov_q, emit_en, can_emit;

	logic          bad, unknown, is_find, match, at_tail, busy, evict_go, free_found;
	logic [SW-1:0] free_idx, slot_idx;
	cnt_t          cnt_n;
	logic          uf;
	key_t          in_key;

	assign in_key = '{req.key_type, req.key_space, req.key_inode, req.key_level,
		req.key_offset};
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rd_addr = IDX_W'(cur_q);
	assign can_emit = !ov_q || rsp.ready;
	assign bad = (7'(slot_q) >= 7'(NUM_SLOTS)) || !used[SW'(slot_q)];
	assign unknown = cmd_q > CMD_RENAME;
	assign is_find = (req.command == CMD_LOOKUP) || (req.command == CMD_ALLOC);
	assign slot_idx = SW'(slot_q);
	assign match = (rd.key == key_q);
	assign at_tail = (cur_q == tail_q);
	assign busy = (rd.cnt.uc != 16'd0) || !cnt_idle(rd.cnt);
	assign evict_go = (bytes_q > limit_q) && (|(used & idle)) && head_vld_q;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				free_found = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	// count and flag commands
	always_comb begin
		cnt_n = rd.cnt;
		uf = 1'b0;
		case (cmd_q)
			CMD_REL_READ: begin
				if (rd.cnt.rc == 16'd0) uf = 1'b1;
				else cnt_n.rc = rd.cnt.rc - 16'd1;
			end
			CMD_REL_WRITE: begin
				if (rd.cnt.wc == 16'd0) uf = 1'b1;
				else cnt_n.wc = rd.cnt.wc - 16'd1;
			end
			CMD_UNLOCK: begin
				if (rd.cnt.lc == 16'd0) uf = 1'b1;
				else cnt_n.lc = rd.cnt.lc - 16'd1;
			end
			CMD_WRITE_REF: begin
				cnt_n.wc = inc_sat(rd.cnt.wc);
				cnt_n.uc = inc_sat(rd.cnt.uc);
			end
			CMD_LOCK: cnt_n.lc = inc_sat(rd.cnt.lc);
			CMD_SET_VALID: cnt_n.flags[FLAG_VALID] = 1'b1;
			CMD_SET_INVALID: cnt_n.flags[FLAG_VALID] = 1'b0;
			CMD_SET_WRITABLE: cnt_n.flags[FLAG_WRITABLE] = 1'b1;
			CMD_SET_CLEAN: cnt_n.flags[FLAG_WRITABLE] = 1'b0;
			default: cnt_n = rd.cnt;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					if (is_find) state_d = head_vld_q ? S_FIND : S_NOTFOUND;
					else state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!unknown && !bad && cmd_q == CMD_RENAME)
					state_d = head_vld_q ? S_FIND : S_NOTFOUND;
				else if (can_emit) state_d = S_IDLE;
			end
			S_FIND: begin
				if (match) begin
					if (cmd_q == CMD_RENAME)
						state_d = (cur_q == slot_idx) ? S_RNKEY : S_RNDROP;
					else if (can_emit) state_d = S_IDLE;
				end else if (at_tail) begin
					state_d = S_NOTFOUND;
				end
			end
			S_NOTFOUND: begin
				if (cmd_q == CMD_ALLOC) state_d = S_EVCHK;
				else if (cmd_q == CMD_RENAME) state_d = S_RNKEY;
				else if (can_emit) state_d = S_IDLE;
			end
			S_RNDROP: state_d = S_RNKEY;
			S_RNKEY: if (can_emit) state_d = S_IDLE;
			S_EVCHK: state_d = evict_go ? S_ROT : S_ALLOC;
			S_ROT: begin
				if (!busy) state_d = rd.cnt.flags[FLAG_WRITABLE] ? S_WB : S_DROPV;
			end
			S_WB: if (can_emit) state_d = S_DROPV;
			S_DROPV: state_d = S_EVCHK;
			S_ALLOC: if (can_emit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		wr = '0;
		wr.addr = IDX_W'(cur_q);
		emit_en = 1'b0;
		emit_d = '0;
		cur_d = cur_q;
		prev_d = prev_q;
		prev_vld_d = prev_vld_q;
		head_d = head_q;
		head_vld_d = head_vld_q;
		tail_d = tail_q;
		bytes_d = bytes_q;
		unique case (state_q)
			S_IDLE: begin
				cur_d = is_find ? head_q : SW'(req.slot);
				prev_vld_d = 1'b0;
			end
			S_EXEC: begin
				if (!unknown && !bad && cmd_q == CMD_RENAME) begin
					cur_d = head_q;
					prev_vld_d = 1'b0;
				end else if (can_emit) begin
					emit_en = 1'b1;
					if (unknown) begin
						emit_d = make_rsp(KIND_RESP, ST_OK, 5'd0, 2'd0, 1'b1);
					end else if (bad) begin
						emit_d = make_rsp(KIND_RESP, ST_MISS, slot_q, 2'd0, 1'b1);
					end else if (uf) begin
						emit_d = make_rsp(KIND_RESP, ST_UNDERFLOW, slot_q, rd.cnt.flags, 1'b1);
					end else begin
						wr.cnt_we = 1'b1;
						wr.cnt = cnt_n;
						emit_d = make_rsp(KIND_RESP, ST_OK, slot_q, cnt_n.flags, 1'b1);
					end
				end
			end
			S_FIND: begin
				if (match) begin
					if (cmd_q != CMD_RENAME && can_emit) begin
						wr.cnt_we = 1'b1;
						wr.cnt = rd.cnt;
						wr.cnt.rc = inc_sat(rd.cnt.rc);
						wr.cnt.uc = inc_sat(rd.cnt.uc);
						emit_en = 1'b1;
						emit_d = make_rsp(KIND_RESP, ST_HIT, 5'(cur_q), rd.cnt.flags, 1'b1);
					end else if (cmd_q == CMD_RENAME && cur_q == slot_idx) begin
						cur_d = slot_idx;
					end
				end else if (!at_tail) begin
					prev_d = cur_q;
					prev_vld_d = 1'b1;
					cur_d = SW'(rd.next);
				end
			end
			S_NOTFOUND: begin
				if (cmd_q == CMD_RENAME) begin
					cur_d = slot_idx;
				end else if (cmd_q != CMD_ALLOC && can_emit) begin
					emit_en = 1'b1;
					emit_d = make_rsp(KIND_RESP, ST_MISS, 5'd0, 2'd0, 1'b1);
				end
			end
			S_RNDROP: begin
				if (!prev_vld_q) begin
					if (at_tail) begin
						head_vld_d = 1'b0;
						tail_d = '0;
					end else begin
						head_d = SW'(rd.next);
					end
				end else begin
					wr.next_we = 1'b1;
					wr.next_addr = IDX_W'(prev_q);
					wr.next_data = rd.next;
					if (at_tail) tail_d = prev_q;
				end
				bytes_d = bytes_q - 32'(rd.bytes);
				wr.free_we = 1'b1;
				cur_d = slot_idx;
			end
			S_RNKEY: begin
				if (can_emit) begin
					wr.key_we = 1'b1;
					wr.key = key_q;
					emit_en = 1'b1;
					emit_d = make_rsp(KIND_RESP, ST_OK, 5'(cur_q), rd.cnt.flags, 1'b1);
				end
			end
			S_EVCHK: cur_d = head_q;
			S_ROT: begin
				if (busy) begin
					wr.cnt_we = 1'b1;
					wr.cnt = rd.cnt;
					wr.cnt.uc = rd.cnt.uc >> 1;
					if (!at_tail) begin
						head_d = SW'(rd.next);
						wr.next_we = 1'b1;
						wr.next_addr = IDX_W'(tail_q);
						wr.next_data = IDX_W'(cur_q);
						tail_d = cur_q;
						cur_d = SW'(rd.next);
					end
				end
			end
			S_WB: begin
				if (can_emit) begin
					emit_en = 1'b1;
					emit_d = make_rsp(KIND_WRITEBACK, ST_OK, 5'(cur_q), rd.cnt.flags, 1'b0);
					wr.cnt_we = 1'b1;
					wr.cnt = rd.cnt;
					wr.cnt.flags[FLAG_WRITABLE] = 1'b0;
				end
			end
			S_DROPV: begin
				if (at_tail) begin
					head_vld_d = 1'b0;
					tail_d = '0;
				end else begin
					head_d = SW'(rd.next);
				end
				bytes_d = bytes_q - 32'(rd.bytes);
				wr.free_we = 1'b1;
			end
			S_ALLOC: begin
				if (can_emit) begin
					emit_en = 1'b1;
					if (!free_found) begin
						emit_d = make_rsp(KIND_RESP, ST_NO_FREE, 5'd0, 2'd0, 1'b1);
					end else begin
						wr.entry_we = 1'b1;
						wr.addr = IDX_W'(free_idx);
						wr.key = key_q;
						wr.bytes = size_q;
						wr.cnt = '{16'd1, 16'd0, 16'd0, 16'd1, 2'd0};
						if (head_vld_q) begin
							wr.next_we = 1'b1;
							wr.next_addr = IDX_W'(tail_q);
							wr.next_data = IDX_W'(free_idx);
						end else begin
							head_d = free_idx;
							head_vld_d = 1'b1;
						end
						tail_d = free_idx;
						bytes_d = bytes_q + 32'(size_q);
						emit_d = make_rsp(KIND_RESP, ST_INSERTED, 5'(free_idx), 2'd0, 1'b1);
					end
				end
			end
			default: emit_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_vld_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			bytes_q <= '0;
			limit_q <= LIMIT_RST;
			ov_q <= 1'b0;
			prev_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_vld_q <= head_vld_d;
			head_q <= head_d;
			tail_q <= tail_d;
			bytes_q <= bytes_d;
			prev_vld_q <= prev_vld_d;
			if (cfg.valid) limit_q <= cfg.data;
			if (emit_en) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		prev_q <= prev_d;
		if (emit_en) out_q <= emit_d;
		if (req.valid && req.ready) begin
			cmd_q <= req.command;
			key_q <= in_key;
			size_q <= req.buf_size;
			slot_q <= req.slot;
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.kind = out_q.kind;
	assign rsp.status = out_q.status;
	assign rsp.result_slot = out_q.result_slot;
	assign rsp.valid_flag = out_q.valid_flag;
	assign rsp.writable_flag = out_q.writable_flag;
	assign rsp.last = out_q.last;

	a_empty_list: assert property (@(posedge clk) disable iff (!arst_n)
		!head_vld_q |-> (used == '0))
		else $error("empty order list with slots in use");
	a_wb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_q.kind == KIND_WRITEBACK) |-> !out_q.last)
		else $error("writeback request marked last");
	a_rot_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT || state_q == S_DROPV) |-> head_vld_q)
		else $error("eviction on empty list");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> (!ov_q || rsp.ready))
		else $error("response overwritten");

endmodule

// File: design/buffer_cache_directory.sv
// Top level of the buffer cache directory: slot store plus command sequencer.
// Depends on bcd_pkg, bcd_if, bcd_slots, bcd_seq.
//
// Usage:
//   req  : one command per request (lookup, alloc, count, flag, rename).
//   rsp  : zero or more writeback requests (kind 1, last 0) followed by one
//          command response with last set.
//   cfg  : byte_limit write, always ready; write only while idle.
// Timing: a request is taken only while the sequencer is idle. Count and
//   flag commands update the slot in the execute state. Lookup and alloc
//   walk the order list one slot per cycle through the single store read
//   port. An evicting alloc rotates busy slots to the tail and frees an idle
//   one, after a writeback request if it is writable. Rename checks its slot
//   before the walk, frees another slot holding the new key, then writes it.
// Reset: order list empty, no slot in use, byte total 0, limit 1048576.
// A stalled rsp holds the sequencer only when it must emit another result;
// the response register frees the request side otherwise.
module buffer_cache_directory import bcd_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	bcd_req_if.sink   req,
	bcd_rsp_if.source rsp,
	bcd_cfg_if.sink   cfg
);
	logic [IDX_W-1:0]     rd_addr;
	slot_rd_t             rd;
	slot_wr_t             wr;
	logic [NUM_SLOTS-1:0] used;
	logic [NUM_SLOTS-1:0] idle;

	bcd_slots #(.NUM_SLOTS(NUM_SLOTS)) u_slots (
		.clk(clk), .arst_n(arst_n), .rd_addr(rd_addr), .rd(rd), .wr(wr),
		.used(used), .idle(idle)
	);

	bcd_seq #(.NUM_SLOTS(NUM_SLOTS)) u_seq (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.rd_addr(rd_addr), .rd(rd), .wr(wr), .used(used), .idle(idle)
	);

endmodule
